// File: rtl/core/owbm_pkg.sv
// Package with types, codes and helpers of the 1-Wire bus master core.
`default_nettype none

package owbm_pkg;

    localparam int BITS_PER_BYTE = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CNT_W      = 10;

    // Item kinds; also used as the running operation code.
    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_RESET  = 3'd1,
        KIND_WBIT   = 3'd2,
        KIND_RBIT   = 3'd3,
        KIND_WBYTE  = 3'd4,
        KIND_RBYTE  = 3'd5
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_PRESENCE_TAIL = 3'd2,
        CFG_SLOT          = 3'd3,
        CFG_READ_RECOVER  = 3'd4,
        CFG_SHORT_LOW     = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RLOW  = 3'd1,
        PH_RWAIT = 3'd2,
        PH_RTAIL = 3'd3,
        PH_WLOW  = 3'd4,
        PH_WHIGH = 3'd5,
        PH_DLOW  = 3'd6,
        PH_DREC  = 3'd7
    } t_phase;

    localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
    localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd60;
    localparam logic [7:0] PRESENCE_TAIL_DEF = 8'd100;
    localparam logic [7:0] SLOT_DEF          = 8'd60;
    localparam logic [7:0] READ_RECOVER_DEF  = 8'd55;
    localparam logic [3:0] SHORT_LOW_DEF     = 4'd1;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_data;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0] tc;
        logic             hit;
    } t_cnt;

    // Advance the phase counter toward len; a zero length acts as one tick.
    function automatic t_cnt count_step(input logic [CNT_W-1:0] tc,
                                        input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] l;
        t_cnt             r;
        l    = (len == '0) ? CNT_W'(1) : len;
        r.tc = tc;
        if (tc < l)
            r.tc = tc + CNT_W'(1);
        r.hit = (r.tc >= l);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/one_wire_bus_master_core.sv
// 1-Wire bus master: reset/presence, bit and byte slots timed by tick items.
// Each accepted item yields one result, registered in the output buffer.
// Throughput: one item per cycle while the skid entry is empty; a two-entry
// buffer (output register plus skid) takes one more item while a result waits on i_ready.
// Synchronous active-low reset: timing registers return to their defaults,
// the sequencer goes idle, presence and read data clear, buffer empties.
`default_nettype none

module one_wire_bus_master_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [owbm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [owbm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // item input channel
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [2:0]                       i_kind,
    input  wire logic [7:0]                       i_tx_data,
    input  wire logic                             i_line_in,
    // result output channel
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_drive_low,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    output logic                                  o_presence,
    output logic [7:0]                            o_rx_data
);
    import owbm_pkg::*;

    logic [9:0] r_reset_low;
    logic [7:0] r_pwait;
    logic [7:0] r_ptail;
    logic [7:0] r_slot;
    logic [7:0] r_recover;
    logic [3:0] r_short;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_tc, n_tc;
    logic [3:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    t_kind            r_op, n_op;
    logic             r_pres, n_pres;
    logic [7:0]       r_rx, n_rx;

    t_result r_out, r_skd, n_res;
    logic    r_out_valid, r_skd_valid;

    logic acc, take, done, fin, wr_mode;
    t_cnt c;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_skd_valid;
    assign acc         = i_valid && o_ready;
    assign take        = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low <= RESET_LOW_DEF;
            r_pwait     <= PRESENCE_WAIT_DEF;
            r_ptail     <= PRESENCE_TAIL_DEF;
            r_slot      <= SLOT_DEF;
            r_recover   <= READ_RECOVER_DEF;
            r_short     <= SHORT_LOW_DEF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RESET_LOW:     r_reset_low <= i_cfg_data;
                CFG_PRESENCE_WAIT: r_pwait     <= i_cfg_data[7:0];
                CFG_PRESENCE_TAIL: r_ptail     <= i_cfg_data[7:0];
                CFG_SLOT:          r_slot      <= i_cfg_data[7:0];
                CFG_READ_RECOVER:  r_recover   <= i_cfg_data[7:0];
                CFG_SHORT_LOW:     r_short     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tc    = r_tc;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_op    = r_op;
        n_pres  = r_pres;
        n_rx    = r_rx;
        done    = 1'b0;
        fin     = 1'b0;
        c       = '0;
        wr_mode = (r_op == KIND_WBIT) || (r_op == KIND_WBYTE);

        if (i_kind == KIND_TICK) begin
            case (r_phase)
                PH_IDLE: ;
                PH_RLOW: begin
                    c    = count_step(r_tc, r_reset_low);
                    n_tc = c.tc;
                    if (c.hit) begin
                        n_phase = PH_RWAIT;
                        n_tc    = '0;
                    end
                end
                PH_RWAIT: begin
                    c    = count_step(r_tc, {2'b00, r_pwait});
                    n_tc = c.tc;
                    if (c.hit) begin
                        n_pres = !i_line_in;
                        if (!i_line_in && (r_ptail != 8'd0)) begin
                            n_phase = PH_RTAIL;
                            n_tc    = '0;
                        end else begin
                            n_phase = PH_IDLE;
                            n_op    = KIND_TICK;
                            done    = 1'b1;
                        end
                    end
                end
                PH_RTAIL: begin
                    c    = count_step(r_tc, {2'b00, r_ptail});
                    n_tc = c.tc;
                    if (c.hit) begin
                        n_phase = PH_IDLE;
                        n_op    = KIND_TICK;
                        done    = 1'b1;
                    end
                end
                PH_WLOW: begin
                    if (r_shift[0]) begin
                        c    = count_step(r_tc, {6'd0, r_short});
                        n_tc = c.tc;
                        if (c.hit) begin
                            n_phase = PH_WHIGH;
                            n_tc    = '0;
                        end
                    end else begin
                        c    = count_step(r_tc, {2'b00, r_slot});
                        n_tc = c.tc;
                        fin  = c.hit;
                    end
                end
                PH_WHIGH: begin
                    c    = count_step(r_tc, {2'b00, r_slot});
                    n_tc = c.tc;
                    fin  = c.hit;
                end
                PH_DLOW: begin
                    c    = count_step(r_tc, {6'd0, r_short});
                    n_tc = c.tc;
                    if (c.hit) begin
                        n_phase = PH_DREC;
                        n_tc    = '0;
                    end
                end
                PH_DREC: begin
                    // sample the bus on the first tick after release
                    if (r_tc == '0)
                        n_shift = {i_line_in, r_shift[7:1]};
                    c    = count_step(r_tc, {2'b00, r_recover});
                    n_tc = c.tc;
                    fin  = c.hit;
                end
                default: n_phase = PH_IDLE;
            endcase

            if (fin) begin
                n_bit = r_bit + 4'd1;
                if (wr_mode)
                    n_shift = {1'b0, n_shift[7:1]};
                if (((r_op == KIND_WBYTE) || (r_op == KIND_RBYTE)) &&
                    (n_bit < 4'(BITS_PER_BYTE))) begin
                    n_tc    = '0;
                    n_phase = wr_mode ? PH_WLOW : PH_DLOW;
                end else begin
                    if (r_op == KIND_RBIT)
                        n_rx = {7'd0, n_shift[7]};
                    else if (r_op == KIND_RBYTE)
                        n_rx = n_shift;
                    n_phase = PH_IDLE;
                    n_op    = KIND_TICK;
                    done    = 1'b1;
                end
            end
        end else if ((i_kind <= KIND_RBYTE) && (r_phase == PH_IDLE)) begin
            n_op  = t_kind'(i_kind);
            n_tc  = '0;
            n_bit = 4'd0;
            if (i_kind == KIND_RESET) begin
                n_phase = PH_RLOW;
            end else begin
                if (i_kind == KIND_WBIT)
                    n_shift = {7'd0, i_tx_data[0]};
                else if (i_kind == KIND_WBYTE)
                    n_shift = i_tx_data;
                else
                    n_shift = 8'd0;
                n_phase = ((i_kind == KIND_WBIT) || (i_kind == KIND_WBYTE)) ?
                          PH_WLOW : PH_DLOW;
            end
        end

        n_res.drive_low = (n_phase == PH_RLOW) || (n_phase == PH_WLOW) ||
                          (n_phase == PH_DLOW);
        n_res.busy_res  = (n_phase != PH_IDLE);
        n_res.done_res  = done;
        n_res.presence  = n_pres;
        n_res.rx_data   = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tc    <= '0;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_op    <= KIND_TICK;
            r_pres  <= 1'b0;
            r_rx    <= 8'd0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_tc    <= n_tc;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_op    <= n_op;
            r_pres  <= n_pres;
            r_rx    <= n_rx;
        end
    end

    // output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (take) begin
            if (r_skd_valid) begin
                r_skd_valid <= 1'b0;
            end else if (!acc) begin
                r_out_valid <= 1'b0;
            end
        end else if (acc) begin
            if (!r_out_valid)
                r_out_valid <= 1'b1;
            else
                r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skd_valid)
                r_out <= r_skd;
            else if (acc)
                r_out <= n_res;
        end else if (acc) begin
            if (!r_out_valid)
                r_out <= n_res;
            else
                r_skd <= n_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_drive_low = r_out.drive_low;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_presence  = r_out.presence;
    assign o_rx_data   = r_out.rx_data;

endmodule

`default_nettype wire
